### sv/tsm_pkg.sv
package tsm_pkg;

  localparam int MAP_ENTRIES = 1024;
  localparam int IDX_W       = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int CNT_W       = IDX_W + 1;
  localparam int KEY_W       = 37;
  localparam int SLOT_OUT_W  = 10;

  typedef enum logic [2:0] {
    OP_IDLE    = 3'd0,
    OP_STORE   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_EXIST   = 3'd3,
    OP_FETCH   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ENT_EMPTY = 2'd0,
    ENT_VALID = 2'd1,
    ENT_TOMB  = 2'd2
  } ent_state_t;

  typedef struct packed {
    ent_state_t             st;
    logic [KEY_W-1:0]       key;
    logic [IDX_W-1:0]       slot;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_ALLOC,
    S_DONE
  } state_t;

  function automatic logic [KEY_W-1:0] pack_key(input logic [15:0] x, input logic [15:0] y,
                                                 input logic [4:0] lvl);
    return {x, y, lvl};
  endfunction

  function automatic logic [IDX_W-1:0] hash_key(input logic [KEY_W-1:0] key);
    logic [IDX_W-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ key[i];
    end
    if ({1'b0, h} >= CNT_W'(MAP_ENTRIES)) begin
      h = h - IDX_W'(MAP_ENTRIES);
    end
    return h;
  endfunction

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] a);
    return (a == IDX_W'(MAP_ENTRIES - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [SLOT_OUT_W-1:0] out_slot(input logic [IDX_W-1:0] s);
    logic [IDX_W+SLOT_OUT_W-1:0] t;
    t = {{SLOT_OUT_W{1'b0}}, s};
    return t[SLOT_OUT_W-1:0];
  endfunction

endpackage

### sv/tsm_if.sv
interface tsm_in_if;
  import tsm_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic signed [15:0] tile_x;
  logic signed [15:0] tile_y;
  logic [4:0]  tile_level;

  modport source (output valid, operation, tile_x, tile_y, tile_level, input ready);
  modport sink (input valid, operation, tile_x, tile_y, tile_level, output ready);
endinterface

interface tsm_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [9:0]  slot;
  logic        newly_allocated;
  logic        full_error;

  modport source (output valid, found, slot, newly_allocated, full_error, input ready);
  modport sink (input valid, found, slot, newly_allocated, full_error, output ready);
endinterface

### sv/tile_slot_map_allocator_core.sv
// channel | dir | words                                     | handshake
// in_ch   | in  | operation, tile_x, tile_y, tile_level     | valid/ready
// out_ch  | out | found, slot, newly_allocated, full_error   | valid/ready
//
// One request at a time: an accept step, one entry-memory probe per cycle
// (linear probing from a folded hash), an extra step on allocation, and a step to
// load the result, which waits while the output register holds an unaccepted result.
// After reset a clearing pass marks every entry empty; in_ch.ready stays low
// meanwhile. A stalled result holds in the output register.
module tile_slot_map_allocator_core
  import tsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tsm_in_if.sink    in_ch,
  tsm_out_if.source out_ch
);

  state_t            st_r, st_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [IDX_W-1:0]  addr_r, addr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              free_seen_r, free_seen_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]  tgt_r, tgt_nxt;
  logic              pop_r, pop_nxt;
  logic [CNT_W-1:0]  fsc_r, fsc_nxt;
  logic [CNT_W-1:0]  nfs_r, nfs_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic              fresh_r, fresh_nxt;
  logic              full_r, full_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [9:0]        out_slot_r, out_slot_nxt;
  logic              out_fresh_r, out_fresh_nxt;
  logic              out_full_r, out_full_nxt;

  logic              e_we;
  logic [IDX_W-1:0]  e_waddr, e_raddr;
  logic [ENTRY_W-1:0] e_wdata, e_rdata;
  logic              s_we;
  logic [IDX_W-1:0]  s_waddr, s_raddr, s_rdata;

  entry_t            ent, wr_ent;
  logic [KEY_W-1:0]  in_key;
  logic [CNT_W-1:0]  fsc_m1;
  logic              hit, empty, last, have_slot;
  logic [IDX_W-1:0]  alloc_slot;

  tsm_ram #(.DEPTH(MAP_ENTRIES), .WIDTH(ENTRY_W)) u_entry_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  tsm_ram #(.DEPTH(MAP_ENTRIES), .WIDTH(IDX_W)) u_stack_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(ent.slot),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign ent       = entry_t'(e_rdata);
  assign e_wdata   = ENTRY_W'(wr_ent);
  assign in_key    = pack_key(in_ch.tile_x, in_ch.tile_y, in_ch.tile_level);
  assign fsc_m1    = fsc_r - 1'b1;
  assign s_raddr   = fsc_m1[IDX_W-1:0];
  assign s_waddr   = fsc_r[IDX_W-1:0];
  assign hit       = (ent.st == ENT_VALID) && (ent.key == key_r);
  assign empty     = (ent.st == ENT_EMPTY);
  assign last      = (cnt_r == CNT_W'(MAP_ENTRIES - 1));
  assign have_slot = (fsc_r != '0) || (nfs_r < CNT_W'(MAP_ENTRIES));
  assign alloc_slot = pop_r ? s_rdata : nfs_r[IDX_W-1:0];

  assign in_ch.ready            = (st_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.found           = out_found_r;
  assign out_ch.slot            = out_slot_r;
  assign out_ch.newly_allocated = out_fresh_r;
  assign out_ch.full_error      = out_full_r;

  always_comb begin
    st_nxt        = st_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    free_seen_nxt = free_seen_r;
    free_idx_nxt  = free_idx_r;
    tgt_nxt       = tgt_r;
    pop_nxt       = pop_r;
    fsc_nxt       = fsc_r;
    nfs_nxt       = nfs_r;
    clr_nxt       = clr_r;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    fresh_nxt     = fresh_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_slot_nxt  = out_slot_r;
    out_fresh_nxt = out_fresh_r;
    out_full_nxt  = out_full_r;
    e_we          = 1'b0;
    e_waddr       = addr_r;
    e_raddr       = next_idx(addr_r);
    s_we          = 1'b0;
    wr_ent        = ent;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      S_CLEAR: begin
        e_we      = 1'b1;
        e_waddr   = clr_r;
        wr_ent    = '0;
        wr_ent.st = ENT_EMPTY;
        clr_nxt   = next_idx(clr_r);
        if (clr_r == IDX_W'(MAP_ENTRIES - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        e_raddr = hash_key(in_key);
        if (in_ch.valid) begin
          op_nxt        = in_ch.operation;
          key_nxt       = in_key;
          addr_nxt      = hash_key(in_key);
          cnt_nxt       = '0;
          free_seen_nxt = 1'b0;
          found_nxt     = 1'b0;
          slot_nxt      = '0;
          fresh_nxt     = 1'b0;
          full_nxt      = 1'b0;
          if (in_ch.operation inside {[OP_STORE:OP_FETCH]}) begin
            st_nxt = S_PROBE;
          end else begin
            st_nxt = S_DONE;
          end
        end
      end
      S_PROBE: begin
        if (hit) begin
          found_nxt = 1'b1;
          slot_nxt  = ent.slot;
          if (op_r == OP_RELEASE) begin
            e_we      = 1'b1;
            wr_ent.st = ENT_TOMB;
            if (fsc_r < CNT_W'(MAP_ENTRIES)) begin
              s_we    = 1'b1;
              fsc_nxt = fsc_r + 1'b1;
            end
          end
          st_nxt = S_DONE;
        end else if (empty || last) begin
          if (op_r == OP_STORE) begin
            if (!have_slot) begin
              full_nxt = 1'b1;
              st_nxt   = S_DONE;
            end else begin
              tgt_nxt = free_seen_r ? free_idx_r : addr_r;
              pop_nxt = (fsc_r != '0);
              st_nxt  = S_ALLOC;
            end
          end else begin
            st_nxt = S_DONE;
          end
        end else begin
          if ((ent.st == ENT_TOMB) && !free_seen_r) begin
            free_seen_nxt = 1'b1;
            free_idx_nxt  = addr_r;
          end
          addr_nxt = next_idx(addr_r);
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      S_ALLOC: begin
        e_we        = 1'b1;
        e_waddr     = tgt_r;
        wr_ent.st   = ENT_VALID;
        wr_ent.key  = key_r;
        wr_ent.slot = alloc_slot;
        slot_nxt    = alloc_slot;
        fresh_nxt   = 1'b1;
        if (pop_r) begin
          fsc_nxt = fsc_m1;
        end else begin
          nfs_nxt = nfs_r + 1'b1;
        end
        st_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_slot_nxt  = out_slot(slot_r);
          out_fresh_nxt = fresh_r;
          out_full_nxt  = full_r;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_r       <= '0;
      fsc_r       <= '0;
      nfs_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      fsc_r       <= fsc_nxt;
      nfs_r       <= nfs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    addr_r      <= addr_nxt;
    cnt_r       <= cnt_nxt;
    free_seen_r <= free_seen_nxt;
    free_idx_r  <= free_idx_nxt;
    tgt_r       <= tgt_nxt;
    pop_r       <= pop_nxt;
    found_r     <= found_nxt;
    slot_r      <= slot_nxt;
    fresh_r     <= fresh_nxt;
    full_r      <= full_nxt;
    out_found_r <= out_found_nxt;
    out_slot_r  <= out_slot_nxt;
    out_fresh_r <= out_fresh_nxt;
    out_full_r  <= out_full_nxt;
  end

endmodule

### sv/tsm_ram.sv
module tsm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### tb/sv/tile_slot_map_allocator_core_chk.sv
`timescale 1ns / 100ps
module tile_slot_map_allocator_core_chk
  import tsm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  tsm_in_if        in_ch,
  tsm_out_if       out_ch,
  output int       fail_count,
  output int       pending_count
);

  typedef struct packed {
    logic       found;
    logic [9:0] slot;
    logic       newly_allocated;
    logic       full_error;
  } tile_result_t;

  bit               map_valid [MAP_ENTRIES];
  logic [KEY_W-1:0] map_key   [MAP_ENTRIES];
  logic [IDX_W-1:0] map_slot  [MAP_ENTRIES];
  logic [IDX_W-1:0] freed_slots [MAP_ENTRIES];
  int               freed_count;
  int               fresh_next;
  tile_result_t     expected_results [$];

  function automatic tile_result_t map_request(input logic [2:0] op,
                                               input logic [KEY_W-1:0] key);
    tile_result_t r;
    int hit;
    int free_idx;
    logic [IDX_W-1:0] s;
    r = '0;
    hit = -1;
    free_idx = -1;
    if (op inside {OP_STORE, OP_RELEASE, OP_EXIST, OP_FETCH}) begin
      for (int i = 0; i < MAP_ENTRIES; i++) begin
        if (hit < 0 && map_valid[i] && map_key[i] == key) hit = i;
        if (free_idx < 0 && !map_valid[i]) free_idx = i;
      end
      if (hit >= 0) begin
        r.found = 1'b1;
        r.slot  = out_slot(map_slot[hit]);
      end
      if (op == OP_STORE && hit < 0) begin
        if (free_idx < 0 || !(freed_count > 0 || fresh_next < MAP_ENTRIES)) begin
          r.full_error = 1'b1;
        end else begin
          if (freed_count > 0) begin
            freed_count--;
            s = freed_slots[freed_count];
          end else begin
            s = IDX_W'(fresh_next);
            fresh_next++;
          end
          map_valid[free_idx] = 1'b1;
          map_key[free_idx]   = key;
          map_slot[free_idx]  = s;
          r.slot = out_slot(s);
          r.newly_allocated = 1'b1;
        end
      end else if (op == OP_RELEASE && hit >= 0) begin
        if (freed_count < MAP_ENTRIES) begin
          freed_slots[freed_count] = map_slot[hit];
          freed_count++;
        end
        map_valid[hit] = 1'b0;
      end
    end
    return r;
  endfunction

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    tile_result_t exp_r;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count  <= 0;
      freed_count = 0;
      fresh_next  = 0;
      for (int i = 0; i < MAP_ENTRIES; i++) map_valid[i] = 1'b0;
      expected_results.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(map_request(in_ch.operation,
            pack_key(in_ch.tile_x, in_ch.tile_y, in_ch.tile_level)));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word");
          errs++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.found !== exp_r.found) begin
            $error("found: expected %0d actual %0d", exp_r.found, out_ch.found);
            errs++;
          end
          if (out_ch.slot !== exp_r.slot) begin
            $error("slot: expected %0d actual %0d", exp_r.slot, out_ch.slot);
            errs++;
          end
          if (out_ch.newly_allocated !== exp_r.newly_allocated) begin
            $error("newly_allocated: expected %0d actual %0d",
                   exp_r.newly_allocated, out_ch.newly_allocated);
            errs++;
          end
          if (out_ch.full_error !== exp_r.full_error) begin
            $error("full_error: expected %0d actual %0d",
                   exp_r.full_error, out_ch.full_error);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

### tb/sv/tile_slot_map_allocator_core_tb.sv
`timescale 1ns / 100ps
module tile_slot_map_allocator_core_tb;
  import tsm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 1'b0;

  logic [15:0] key_x [16];
  logic [15:0] key_y [16];
  logic [4:0]  key_lvl [16];

  tsm_in_if  in_ch ();
  tsm_out_if out_ch ();

  tile_slot_map_allocator_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tile_slot_map_allocator_core_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(input logic [2:0] op, input logic [15:0] x,
                           input logic [15:0] y, input logic [4:0] lvl);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.tile_x     <= x;
    in_ch.tile_y     <= y;
    in_ch.tile_level <= lvl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random(input int count, input int key_span);
    int k;
    int pick;
    logic [2:0] op;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) op = OP_STORE;
      else if (pick < 65) op = OP_RELEASE;
      else if (pick < 80) op = OP_EXIST;
      else if (pick < 94) op = OP_FETCH;
      else op = 3'($urandom_range(7));
      if ($urandom_range(9) == 0) begin
        send_word(op, 16'($urandom), 16'($urandom), 5'($urandom));
      end else begin
        k = $urandom_range(key_span - 1);
        send_word(op, key_x[k], key_y[k], key_lvl[k]);
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_IDLE;
    in_ch.tile_x = '0;
    in_ch.tile_y = '0;
    in_ch.tile_level = '0;
    for (int i = 0; i < 16; i++) begin
      key_x[i]   = 16'($urandom);
      key_y[i]   = 16'($urandom);
      key_lvl[i] = 5'($urandom);
    end
    key_x[1] = 16'h8000; key_y[1] = 16'h7fff; key_lvl[1] = 5'd31;
    key_x[2] = 16'h7fff; key_y[2] = 16'h8000; key_lvl[2] = 5'd0;
    key_x[3] = key_x[2]; key_y[3] = key_y[2]; key_lvl[3] = 5'd1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_word(OP_IDLE, 16'hffff, 16'hffff, 5'd31);
    send_word(OP_RELEASE, key_x[1], key_y[1], key_lvl[1]);
    send_word(OP_EXIST, key_x[1], key_y[1], key_lvl[1]);
    send_word(OP_STORE, key_x[1], key_y[1], key_lvl[1]);
    send_word(OP_STORE, key_x[1], key_y[1], key_lvl[1]);
    send_word(OP_STORE, key_x[2], key_y[2], key_lvl[2]);
    send_word(OP_FETCH, key_x[3], key_y[3], key_lvl[3]);
    send_word(OP_STORE, key_x[3], key_y[3], key_lvl[3]);
    send_word(OP_FETCH, key_x[2], key_y[2], key_lvl[2]);
    send_word(OP_RELEASE, key_x[1], key_y[1], key_lvl[1]);
    send_word(OP_RELEASE, key_x[2], key_y[2], key_lvl[2]);
    send_word(OP_STORE, key_x[4], key_y[4], key_lvl[4]);
    send_word(OP_STORE, key_x[5], key_y[5], key_lvl[5]);
    send_word(OP_EXIST, key_x[4], key_y[4], key_lvl[4]);
    send_word(3'd5, key_x[4], key_y[4], key_lvl[4]);
    send_word(3'd6, 16'h0, 16'h0, 5'd0);
    send_word(3'd7, 16'h0, 16'h0, 5'd0);

    send_random(150, 16);
    send_idle_pct = 80;
    send_random(100, 16);
    send_idle_pct = 0;
    recv_stall_pct = 80;
    send_random(100, 16);
    send_idle_pct = 8;
    recv_stall_pct = 8;
    send_random(100, 16);

    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      send_random(30, 16);
    join

    // fill the map beyond capacity, release some entries, then store into the freed room
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < MAP_ENTRIES + 4; n++) begin
      send_word(OP_STORE, 16'(n), 16'(~n), 5'(n));
    end
    send_word(OP_STORE, 16'h1234, 16'h4321, 5'd7);
    for (int n = 0; n < 40; n++) begin
      send_word(OP_RELEASE, 16'(n * 3), 16'(~(n * 3)), 5'(n * 3));
    end
    for (int n = 0; n < 45; n++) begin
      send_word(OP_STORE, 16'h4000 + 16'(n), 16'h0, 5'd2);
    end
    send_random(40, 16);
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (MAP_ENTRIES + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #250ms;
    $display("FAILURE");
    $finish;
  end

endmodule
